[hw/rtl/urbf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package urbf_pkg;

  // opcodes of an input item
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_RECV  = 3'd2;
  localparam logic [2:0] OP_READY = 3'd3;
  localparam logic [2:0] OP_FLUSH = 3'd4;

  // input item
  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] byte_in;
  } in_item_t;

  // result item
  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_data;
    logic [5:0] rx_count;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       write_accepted;
    logic       rx_dropped;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic do_read;
    logic do_write_direct;
    logic do_write_queue;
    logic do_recv;
    logic do_ready_pop;
    logic do_ready_free;
    logic do_flush;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       rx_empty;
    logic       tx_empty;
    logic       tx_full;
    logic       tx_free;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/urbf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module urbf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire urbf_pkg::sts_t sts,
  output urbf_pkg::cmd_t      cmd
);
  import urbf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // sequencing: take item, execute, hold result until taken
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // opcode decode during execute
  always_comb begin
    cmd         = '0;
    cmd.capture = (state_r == S_IDLE) && in_valid;
    if (state_r == S_EXEC) begin
      cmd.load_out = 1'b1;
      unique case (sts.op)
        OP_READ:  cmd.do_read = !sts.rx_empty;
        OP_WRITE: begin
          if (sts.tx_empty && sts.tx_free) begin
            cmd.do_write_direct = 1'b1;
          end else if (!sts.tx_full) begin
            cmd.do_write_queue = 1'b1;
          end
        end
        OP_RECV:  cmd.do_recv = 1'b1;
        OP_READY: begin
          cmd.do_ready_pop  = !sts.tx_empty;
          cmd.do_ready_free = sts.tx_empty;
        end
        OP_FLUSH: cmd.do_flush = 1'b1;
        default:  cmd.load_out = 1'b1;
      endcase
    end
  end

  // an accepted item always goes to execute next
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execute");

  // execute is always followed by a pending result
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> out_valid)
    else $error("no result after execute");

  // at most one transmit command is issued: a host write is sent directly or queued, never both
  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_write_direct, cmd.do_write_queue, cmd.do_ready_pop, cmd.do_ready_free}))
    else $error("conflicting transmit commands");

  // no new item is taken while a result waits
  a_no_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

endmodule

`default_nettype wire

[hw/rtl/urbf_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module urbf_datapath #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire urbf_pkg::cmd_t     cmd,
  input  wire urbf_pkg::in_item_t in_item,
  output urbf_pkg::sts_t          sts,
  output urbf_pkg::out_item_t     out_item
);
  import urbf_pkg::*;

  localparam int RPW = $clog2(RX_DEPTH);
  localparam int TPW = $clog2(TX_DEPTH);

  logic [2:0]     op_r;
  logic [7:0]     byte_r;
  logic [RPW-1:0] rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt, rx_wp_inc, rx_rp_inc;
  logic [TPW-1:0] tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt, tx_wp_inc, tx_rp_inc;
  logic           tx_free_r, tx_free_nxt;
  logic           drop;
  logic [7:0]     rx_rd_data_r, tx_rd_data_r;
  logic [RPW:0]   rx_cnt_wide;
  logic [RPW-1:0] rx_cnt;
  logic [31:0]    rx_cnt_ext;
  out_item_t      out_r;

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_item.opcode;
      byte_r <= in_item.byte_in;
    end
  end

  // ring memories, read at the head while the item is captured
  always_ff @(posedge clk) begin
    if (cmd.do_recv) rx_mem[rx_wp_r] <= byte_r;
    if (cmd.capture) rx_rd_data_r <= rx_mem[rx_rp_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.do_write_queue) tx_mem[tx_wp_r] <= byte_r;
    if (cmd.capture) tx_rd_data_r <= tx_mem[tx_rp_r];
  end

  // wrapping pointer increments
  assign rx_wp_inc = (rx_wp_r == RPW'(RX_DEPTH - 1)) ? '0 : rx_wp_r + 1'b1;
  assign rx_rp_inc = (rx_rp_r == RPW'(RX_DEPTH - 1)) ? '0 : rx_rp_r + 1'b1;
  assign tx_wp_inc = (tx_wp_r == TPW'(TX_DEPTH - 1)) ? '0 : tx_wp_r + 1'b1;
  assign tx_rp_inc = (tx_rp_r == TPW'(TX_DEPTH - 1)) ? '0 : tx_rp_r + 1'b1;

  // status to controller
  assign sts.op       = op_r;
  assign sts.rx_empty = (rx_wp_r == rx_rp_r);
  assign sts.tx_empty = (tx_wp_r == tx_rp_r);
  assign sts.tx_full  = (tx_wp_inc == tx_rp_r);
  assign sts.tx_free  = tx_free_r;

  // receive ring pointer update, oldest entry dropped when full, flush empties the ring
  always_comb begin
    rx_wp_nxt = rx_wp_r;
    rx_rp_nxt = rx_rp_r;
    drop      = 1'b0;
    if (cmd.do_read) rx_rp_nxt = rx_rp_inc;
    if (cmd.do_recv) begin
      rx_wp_nxt = rx_wp_inc;
      if (rx_wp_inc == rx_rp_r) begin
        rx_rp_nxt = rx_rp_inc;
        drop      = 1'b1;
      end
    end
    if (cmd.do_flush) begin
      rx_wp_nxt = '0;
      rx_rp_nxt = '0;
    end
  end

  // transmit ring and transmitter state
  always_comb begin
    tx_wp_nxt   = tx_wp_r;
    tx_rp_nxt   = tx_rp_r;
    tx_free_nxt = tx_free_r;
    if (cmd.do_write_direct) tx_free_nxt = 1'b0;
    if (cmd.do_write_queue) tx_wp_nxt = tx_wp_inc;
    if (cmd.do_ready_pop) begin
      tx_rp_nxt   = tx_rp_inc;
      tx_free_nxt = 1'b0;
    end
    if (cmd.do_ready_free) tx_free_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wp_r   <= '0;
      rx_rp_r   <= '0;
      tx_wp_r   <= '0;
      tx_rp_r   <= '0;
      tx_free_r <= 1'b1;
    end else begin
      rx_wp_r   <= rx_wp_nxt;
      rx_rp_r   <= rx_rp_nxt;
      tx_wp_r   <= tx_wp_nxt;
      tx_rp_r   <= tx_rp_nxt;
      tx_free_r <= tx_free_nxt;
    end
  end

  // receive count after this item
  assign rx_cnt_wide = ({1'b0, rx_wp_nxt} + (RPW + 1)'(RX_DEPTH)) - {1'b0, rx_rp_nxt};
  assign rx_cnt      = (rx_wp_nxt >= rx_rp_nxt) ? (rx_wp_nxt - rx_rp_nxt)
                                                 : rx_cnt_wide[RPW-1:0];
  assign rx_cnt_ext  = 32'(rx_cnt);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.read_valid     <= cmd.do_read;
      out_r.read_data      <= cmd.do_read ? rx_rd_data_r : 8'd0;
      out_r.rx_count       <= rx_cnt_ext[5:0];
      out_r.tx_valid       <= cmd.do_write_direct | cmd.do_ready_pop;
      out_r.tx_byte        <= cmd.do_write_direct ? byte_r :
                              cmd.do_ready_pop    ? tx_rd_data_r : 8'd0;
      out_r.write_accepted <= cmd.do_write_direct | cmd.do_write_queue;
      out_r.rx_dropped     <= drop;
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

[hw/rtl/uart_ring_buffer_front.sv]
// Buffered front of a serial port: a receive ring and a transmit ring.
// Input channel (in_valid / in_stall / in_item) carries one item: an opcode
// (host read, host write, byte received, transmitter ready, flush) and a
// data byte. Every item yields exactly one result item on the output
// channel (out_valid / out_stall / out_item), carrying the popped byte, the
// byte handed to the transmitter, write acceptance, the overwrite flag and
// the receive count after the item.
// Each accepted item passes the capture / execute / result sequence of the
// controller, with one registered read of each ring memory; no new item is
// accepted until the result of the last one has been taken.
// in_stall is high from acceptance until the result has been taken; while
// out_stall is high the result holds and no new item is accepted.
// Reset (rst_n low, synchronous) empties both rings, marks the transmitter
// free and drops any pending result; ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module uart_ring_buffer_front #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire urbf_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output urbf_pkg::out_item_t     out_item
);
  import urbf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  urbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  urbf_datapath #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
